// File: src/lmsp_pkg.sv
// ----------------------------------------------------------------------------
// lmsp_pkg
// Shared codes and types of the minimal standard generator: request action
// codes, the decoded operation and the queue entry between front and back.
// ----------------------------------------------------------------------------
package lmsp_pkg;

   // Action codes as they arrive on the request channel.
   localparam logic [1:0] ACT_NEXT   = 2'd0;
   localparam logic [1:0] ACT_MOD    = 2'd1;
   localparam logic [1:0] ACT_COMB   = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Width of a positive bound once the sign bit is known to be clear.
   localparam int BOUND_W = 31;

   typedef enum logic [1:0] {
      OP_NEXT,
      OP_MOD,
      OP_COMB,
      OP_NONE
   } lmsp_op_type;

   typedef struct packed {
      lmsp_op_type         op;
      logic                bad;
      logic [BOUND_W-1:0]  bound;
   } lmsp_entry_type;

endpackage

// File: src/lmsp_if.sv
// ----------------------------------------------------------------------------
// lmsp_if
// Valid/ready channels of the generator: the request channel and the
// response channel.
// ----------------------------------------------------------------------------
interface lmsp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [31:0] range_bound;

   modport source (output valid, output action, output range_bound, input ready);
   modport sink   (input valid, input action, input range_bound, output ready);
endinterface

interface lmsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [61:0] value;
   logic        bad_bound;

   modport source (output valid, output value, output bad_bound, input ready);
   modport sink   (input valid, input value, input bad_bound, output ready);
endinterface

// File: src/lehmer_minimal_standard_prng_top.sv
// ----------------------------------------------------------------------------
// lehmer_minimal_standard_prng_top
// Minimal standard multiplicative generator (multiplier 16807, modulus
// 2^31-1) with next-value, bounded and 62-bit combined requests.
// ----------------------------------------------------------------------------
// Usage:
// An item on req_chan carries an action and a signed bound. Each item gives
// exactly one item on rsp_chan: the value and a flag for a bound of zero or
// below. Both channels are valid/ready; an item moves when both are high.
// Writing csr_write_data with csr_write_enable loads the generator state;
// do so only while no request is outstanding.
// The back end works on one item at a time and takes the next only when it
// is idle again. A next value, or a bounded request with a bad bound, passes
// the multiply, fold and done states; a combined value runs multiply and fold
// twice, then the combination; a bounded value adds the 32-step bit-serial
// remainder; an unused action code goes straight to done.
// Reset returns the state to a seed of 1 and empties the queue and the
// response register. When the receiver stalls, the finished item waits in
// the response register while the back end finishes the next one, and the
// queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
module lehmer_minimal_standard_prng_top import lmsp_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   lmsp_req_if.sink     req_chan,
   lmsp_rsp_if.source   rsp_chan,
   input  logic         csr_write_enable,
   input  logic [31:0]  csr_write_data
);

   // Classified items travel from the front end into the queue.
   lmsp_entry_type push_data;
   lmsp_entry_type pop_data;
   logic           push_valid, push_ready;
   logic           pop_valid, pop_ready;

   // The front end decodes the action and flags a bad bound up front, so
   // the back end only has to carry out the work.
   lmsp_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // The queue lets the front keep accepting while the back end is busy.
   lmsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // The back end owns the generator state and the response register.
   lmsp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

`ifndef ASSERT_OFF
   // A flagged bound always comes with a zero value.
   a_bad_bound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.bad_bound |-> rsp_chan.value == '0)
      else $error("bad bound response carries a nonzero value");

   // An item pushed into an empty queue is offered to the back end next.
   a_queue_visible: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_ready && !pop_valid |=> pop_valid)
      else $error("pushed item not visible at the queue output");

   // An item taken by the back end keeps it busy for at least the next cycle.
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop_valid && pop_ready |=> !pop_ready)
      else $error("back end took an item but stayed idle");
`endif

endmodule

// File: src/lmsp_front.sv
// ----------------------------------------------------------------------------
// lmsp_front
// Request front end: decodes the action and checks the bound, then hands
// the classified item to the queue.
// ----------------------------------------------------------------------------
module lmsp_front import lmsp_pkg::*; (
   lmsp_req_if.sink        req_chan,
   output logic            push_valid,
   input  logic            push_ready,
   output lmsp_entry_type  push_data
);

   lmsp_op_type op;

   always_comb begin
      unique case (req_chan.action)
         ACT_NEXT:   op = OP_NEXT;
         ACT_MOD:    op = OP_MOD;
         ACT_COMB:   op = OP_COMB;
         ACT_UNUSED: op = OP_NONE;
         default:    op = OP_NONE;
      endcase
   end

   assign push_valid       = req_chan.valid;
   assign req_chan.ready   = push_ready;
   assign push_data.op     = op;
   // A bound of zero or below is flagged; the state still advances.
   assign push_data.bad    = (op == OP_MOD) &&
                             ((req_chan.range_bound == '0) || req_chan.range_bound[31]);
   assign push_data.bound  = req_chan.range_bound[BOUND_W-1:0];

endmodule

// File: src/lmsp_queue.sv
// ----------------------------------------------------------------------------
// lmsp_queue
// Small register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module lmsp_queue import lmsp_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  lmsp_entry_type  push_data,
   output logic            pop_valid,
   input  logic            pop_ready,
   output lmsp_entry_type  pop_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   lmsp_entry_type  mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/lmsp_back.sv
// ----------------------------------------------------------------------------
// lmsp_back
// Execution back end: owns the generator state, runs the split multiply and
// fold, the bit-serial remainder and the 62-bit combination, and holds the
// response register.
// ----------------------------------------------------------------------------
module lmsp_back import lmsp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  lmsp_entry_type  pop_data,
   lmsp_rsp_if.source      rsp_chan,
   input  logic            csr_write_enable,
   input  logic [31:0]     csr_write_data
);

   localparam logic [31:0] MULTIPLIER = 32'd16807;
   localparam logic [31:0] MODULUS    = 32'h7FFF_FFFF;
   localparam logic [31:0] SEED_RESET = 32'd1;
   localparam int          DIV_STEPS  = 32;
   localparam int          CNT_W      = $clog2(DIV_STEPS);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_FOLD = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_COMB = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type           st_ff, st_in;
   logic [31:0]         gen_ff, gen_in;
   logic                out_valid_ff, out_valid_in;
   logic [61:0]         out_value_ff, out_value_in;
   logic                out_bad_ff, out_bad_in;
   lmsp_op_type         op_ff, op_in;
   logic                bad_ff, bad_in;
   logic [BOUND_W-1:0]  bound_ff, bound_in;
   logic                pass_ff, pass_in;
   logic [31:0]         lo_ff, lo_in;
   logic [31:0]         hi_ff, hi_in;
   logic [31:0]         first_ff, first_in;
   logic [31:0]         dv_ff, dv_in;
   logic [BOUND_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [61:0]         res_ff, res_in;
   logic                res_bad_ff, res_bad_in;

   logic [31:0]         fold_a, fold_b, fold_c, fold_val;
   logic [31:0]         trial;
   logic                trial_ge;
   logic [32:0]         first_m1;
   logic [61:0]         first_ext, comb_val;
   logic                out_free;

   // Fold the two partial products: 2^31 is congruent to 1.
   always_comb begin
      fold_a   = lo_ff + {hi_ff[14:0], 16'b0};
      fold_b   = (fold_a > MODULUS) ? ((fold_a & MODULUS) + 32'd1) : fold_a;
      fold_c   = fold_b + {15'b0, hi_ff[31:15]};
      fold_val = (fold_c > MODULUS) ? ((fold_c & MODULUS) + 32'd1) : fold_c;
   end

   // One restoring step of the remainder.
   assign trial    = {rem_ff, dv_ff[31]};
   assign trial_ge = (trial >= {1'b0, bound_ff});

   // (first - 1) * (2^31 - 2) + second, with the multiply as shifts.
   assign first_m1  = {1'b0, first_ff} - 33'd1;
   assign first_ext = {{29{first_m1[32]}}, first_m1};
   assign comb_val  = (first_ext << 31) - (first_ext << 1) + {30'b0, gen_ff};

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign pop_ready = (st_ff == ST_IDLE);

   always_comb begin
      st_in        = st_ff;
      gen_in       = gen_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_bad_in   = out_bad_ff;
      op_in        = op_ff;
      bad_in       = bad_ff;
      bound_in     = bound_ff;
      pass_in      = pass_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      first_in     = first_ff;
      dv_in        = dv_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      res_bad_in   = res_bad_ff;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (st_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               op_in    = pop_data.op;
               bad_in   = pop_data.bad;
               bound_in = pop_data.bound;
               pass_in  = 1'b0;
               if (pop_data.op == OP_NONE) begin
                  res_in     = '0;
                  res_bad_in = 1'b0;
                  st_in      = ST_DONE;
               end else begin
                  st_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            lo_in = MULTIPLIER * {16'b0, gen_ff[15:0]};
            hi_in = MULTIPLIER * {16'b0, gen_ff[31:16]};
            st_in = ST_FOLD;
         end
         ST_FOLD: begin
            gen_in = fold_val;
            unique case (op_ff)
               OP_NEXT: begin
                  res_in     = {30'b0, fold_val};
                  res_bad_in = 1'b0;
                  st_in      = ST_DONE;
               end
               OP_MOD: begin
                  if (bad_ff) begin
                     res_in     = '0;
                     res_bad_in = 1'b1;
                     st_in      = ST_DONE;
                  end else begin
                     dv_in  = fold_val;
                     rem_in = '0;
                     cnt_in = '0;
                     st_in  = ST_DIV;
                  end
               end
               OP_COMB: begin
                  if (!pass_ff) begin
                     first_in = fold_val;
                     pass_in  = 1'b1;
                     st_in    = ST_MUL;
                  end else begin
                     st_in = ST_COMB;
                  end
               end
               default: begin
                  st_in = ST_IDLE;
               end
            endcase
         end
         ST_DIV: begin
            rem_in = trial_ge ? BOUND_W'(trial - {1'b0, bound_ff}) : trial[BOUND_W-1:0];
            dv_in  = {dv_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               res_in     = {31'b0, rem_in};
               res_bad_in = 1'b0;
               st_in      = ST_DONE;
            end
         end
         ST_COMB: begin
            res_in     = comb_val;
            res_bad_in = 1'b0;
            st_in      = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = res_ff;
               out_bad_in   = res_bad_ff;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      // Seed writes load the state directly; the user must write only while idle, as the block does not enforce it.
      if (csr_write_enable) begin
         gen_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         gen_ff       <= SEED_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         gen_ff       <= gen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_bad_ff   <= out_bad_in;
      op_ff        <= op_in;
      bad_ff       <= bad_in;
      bound_ff     <= bound_in;
      pass_ff      <= pass_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      first_ff     <= first_in;
      dv_ff        <= dv_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      res_ff       <= res_in;
      res_bad_ff   <= res_bad_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.value     = out_value_ff;
   assign rsp_chan.bad_bound = out_bad_ff;

endmodule
